// ===== src/clt_pkg.sv =====
package clt_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned OUT_BITS          = 16;
  localparam int unsigned QUEUE_DEPTH       = 4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_EQUAL = 8'h3d;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;

  typedef enum logic [2:0] {
    KIND_LITERAL  = 3'd0,
    KIND_STRING   = 3'd1,
    KIND_NUMBER   = 3'd2,
    KIND_BOOL     = 3'd3,
    KIND_EQUAL    = 3'd4,
    KIND_END      = 3'd5,
    KIND_INVALID  = 3'd6,
    KIND_UNCLOSED = 3'd7
  } token_kind_e;

  typedef struct packed {
    token_kind_e           kind;
    logic                  bval;
    logic [OUT_BITS-1:0]   start;
    logic [OUT_BITS-1:0]   len;
  } token_t;

  // One queue entry: every token that one character gave rise to.
  typedef struct packed {
    token_t tok0;
    token_t tok1;
    logic   two;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

  function automatic logic [7:0] true_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = 8'h74; // t
      2'd1:    ch = 8'h72; // r
      2'd2:    ch = 8'h75; // u
      default: ch = 8'h65; // e
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h66; // f
      3'd1:    ch = 8'h61; // a
      3'd2:    ch = 8'h6c; // l
      3'd3:    ch = 8'h73; // s
      3'd4:    ch = 8'h65; // e
      default: ch = CHAR_NUL;
    endcase
    return ch;
  endfunction

  function automatic token_t mk_tok(input token_kind_e kind, input logic bval,
                                    input logic [OUT_BITS-1:0] start,
                                    input logic [OUT_BITS-1:0] len);
    token_t t;
    t.kind  = kind;
    t.bval  = bval;
    t.start = start;
    t.len   = len;
    return t;
  endfunction

endpackage

// ===== src/clt_if.sv =====
interface clt_chr_if ();
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface

interface clt_tok_if import clt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          token_kind;
  logic                bool_value;
  logic [OUT_BITS-1:0] token_start;
  logic [OUT_BITS-1:0] token_length;
  logic                last_of_run;

  modport source (output valid, output token_kind, output bool_value, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input bool_value, input token_start,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== src/clt_front.sv =====
module clt_front import clt_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  clt_chr_if.sink       chr_i,
  input  q_status_t     q_status_i,
  output logic          push_o,
  output pair_t         pair_o
);

  localparam int unsigned PB = POSITION_BITS;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_STRING  = 2'd1;
  localparam logic [1:0] MODE_NUMBER  = 2'd2;
  localparam logic [1:0] MODE_LITERAL = 2'd3;

  logic [1:0]    mode_q, mode_d;
  logic [PB-1:0] pos_q, pos_d;
  logic [PB-1:0] start_q, start_d;
  logic [PB-1:0] len_q, len_d;
  logic          t_alive_q, t_alive_d;
  logic          f_alive_q, f_alive_d;

  logic          at_end;
  logic          term;
  logic          accept;
  logic          prim_has, idle_has, do_idle;
  token_t        prim_tok, idle_tok;
  logic [7:0]    c;
  logic [2:0]    f_idx;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Clamp a position to the width of the result fields.
  function automatic logic [OUT_BITS-1:0] to_out(input logic [PB-1:0] v);
    logic [PB+OUT_BITS-1:0] ext;
    ext = {{OUT_BITS{1'b0}}, v};
    return (ext[PB+OUT_BITS-1:OUT_BITS] != '0) ? '1 : ext[OUT_BITS-1:0];
  endfunction

  assign c      = chr_i.character;
  assign at_end = chr_i.end_of_text || (c == CHAR_NUL);
  assign term   = at_end || is_white(c);
  assign f_idx  = (len_q < PB'(5)) ? len_q[2:0] : 3'd0;

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    start_d   = start_q;
    len_d     = len_q;
    t_alive_d = t_alive_q;
    f_alive_d = f_alive_q;
    prim_has  = 1'b0;
    prim_tok  = '0;
    do_idle   = 1'b0;
    idle_has  = 1'b0;
    idle_tok  = '0;

    case (mode_q)
      MODE_STRING: begin
        if (at_end) begin
          prim_has = 1'b1;
          prim_tok = mk_tok(KIND_UNCLOSED, 1'b0, to_out(start_q), to_out(len_q));
          do_idle  = 1'b1;
        end else if (c == CHAR_QUOTE) begin
          prim_has = 1'b1;
          prim_tok = mk_tok(KIND_STRING, 1'b0, to_out(start_q), to_out(len_q));
          mode_d   = MODE_IDLE;
          pos_d    = sat_inc(pos_q);
        end else begin
          len_d = sat_inc(len_q);
          pos_d = sat_inc(pos_q);
        end
      end
      MODE_NUMBER: begin
        if (!at_end && is_digit(c)) begin
          len_d = sat_inc(len_q);
          pos_d = sat_inc(pos_q);
        end else begin
          prim_has = 1'b1;
          prim_tok = mk_tok(KIND_NUMBER, 1'b0, to_out(start_q), to_out(len_q));
          do_idle  = 1'b1;
        end
      end
      MODE_LITERAL: begin
        if (!at_end && (is_lower(c) || is_digit(c))) begin
          t_alive_d = t_alive_q && (len_q < PB'(4)) && (c == true_char(len_q[1:0]));
          f_alive_d = f_alive_q && (len_q < PB'(5)) && (c == false_char(f_idx));
          len_d     = sat_inc(len_q);
          pos_d     = sat_inc(pos_q);
        end else begin
          prim_has = 1'b1;
          if (term && t_alive_q && (len_q == PB'(4))) begin
            prim_tok = mk_tok(KIND_BOOL, 1'b1, to_out(start_q), to_out(len_q));
          end else if (term && f_alive_q && (len_q == PB'(5))) begin
            prim_tok = mk_tok(KIND_BOOL, 1'b0, to_out(start_q), to_out(len_q));
          end else begin
            prim_tok = mk_tok(KIND_LITERAL, 1'b0, to_out(start_q), to_out(len_q));
          end
          t_alive_d = 1'b0;
          f_alive_d = 1'b0;
          do_idle   = 1'b1;
        end
      end
      default: do_idle = 1'b1;
    endcase

    // Handle the character as if no run were open; runs after any closing token.
    if (do_idle) begin
      mode_d = MODE_IDLE;
      if (at_end) begin
        idle_has  = 1'b1;
        idle_tok  = mk_tok(KIND_END, 1'b0, to_out(pos_q), '0);
        pos_d     = '0;
        start_d   = '0;
        len_d     = '0;
        t_alive_d = 1'b0;
        f_alive_d = 1'b0;
      end else begin
        if (c == CHAR_SPACE) begin
          // skip
        end else if (c == CHAR_EQUAL) begin
          idle_has = 1'b1;
          idle_tok = mk_tok(KIND_EQUAL, 1'b0, to_out(pos_q), OUT_BITS'(1));
        end else if (c == CHAR_QUOTE) begin
          mode_d  = MODE_STRING;
          start_d = sat_inc(pos_q);
          len_d   = '0;
        end else if (is_digit(c)) begin
          mode_d  = MODE_NUMBER;
          start_d = pos_q;
          len_d   = PB'(1);
        end else if (is_lower(c)) begin
          mode_d    = MODE_LITERAL;
          start_d   = pos_q;
          len_d     = PB'(1);
          t_alive_d = (c == true_char(2'd0));
          f_alive_d = (c == false_char(3'd0));
        end else begin
          idle_has = 1'b1;
          idle_tok = mk_tok(KIND_INVALID, 1'b0, to_out(pos_q), OUT_BITS'(1));
        end
        pos_d = sat_inc(pos_q);
      end
    end
  end

  always_comb begin
    pair_o = '0;
    if (prim_has) begin
      pair_o.tok0 = prim_tok;
      pair_o.tok1 = idle_tok;
      pair_o.two  = idle_has;
    end else begin
      pair_o.tok0 = idle_tok;
    end
  end

  assign chr_i.ready = !q_status_i.full;
  assign accept      = chr_i.valid && chr_i.ready;
  assign push_o      = accept && (prim_has || idle_has);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      pos_q     <= '0;
      start_q   <= '0;
      len_q     <= '0;
      t_alive_q <= 1'b0;
      f_alive_q <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      len_q     <= len_d;
      t_alive_q <= t_alive_d;
      f_alive_q <= f_alive_d;
    end
  end

endmodule

// ===== src/clt_queue.sv =====
module clt_queue import clt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pair_t     pair_i,
  input  logic      pop_i,
  output pair_t     head_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);

  pair_t               mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_BITS:0]   count_q;

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/clt_back.sv =====
module clt_back import clt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pair_t     head_i,
  input  q_status_t q_status_i,
  output logic      pop_o,
  clt_tok_if.source tok_o
);

  logic   idx_q;
  logic   last;
  logic   fire;
  token_t cur;

  assign cur  = idx_q ? head_i.tok1 : head_i.tok0;
  assign last = idx_q || !head_i.two;

  assign tok_o.valid        = !q_status_i.empty;
  assign tok_o.token_kind   = cur.kind;
  assign tok_o.bool_value   = cur.bval;
  assign tok_o.token_start  = cur.start;
  assign tok_o.token_length = cur.len;
  assign tok_o.last_of_run  = last;

  assign fire  = tok_o.valid && tok_o.ready;
  assign pop_o = fire && last;

  // Step through the entry one token per beat; drop it after its last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 1'b0;
    end else if (fire) begin
      idx_q <= !last;
    end
  end

endmodule

// ===== src/command_line_tokenizer.sv =====
// Channel | Dir | Beat payload
// chr_i   | in  | character[7:0], end_of_text
// tok_o   | out | token_kind[2:0], bool_value, token_start[15:0], token_length[15:0],
//         |     | last_of_run
//
// One character is taken per cycle unless the queue is full; the scanner updates
// its run state in that cycle. A character yields up to two tokens, queued as one
// entry and sent one per beat. The four-entry queue absorbs output stalls;
// chr_i.ready falls only when the queue is full.
// Reset (rst_ni low, asynchronous) empties the queue and rearms the scanner.
module command_line_tokenizer import clt_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clt_chr_if.sink   chr_i,
  clt_tok_if.source tok_o
);

  logic      push;
  logic      pop;
  pair_t     push_pair;
  pair_t     head;
  q_status_t q_status;

  clt_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .chr_i      (chr_i),
    .q_status_i (q_status),
    .push_o     (push),
    .pair_o     (push_pair)
  );

  clt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pair_i   (push_pair),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  clt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .tok_o      (tok_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import clt_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 100;

  localparam logic [31:0] TRUE_WORD  = "true";
  localparam logic [39:0] FALSE_WORD = "false";

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_STRING,
    SCAN_NUMBER,
    SCAN_LITERAL
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_beat_t;

  typedef struct packed {
    token_kind_e kind;
    logic        bval;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_beat_t;

  logic clk_i;
  logic rst_ni;

  clt_chr_if chr ();
  clt_tok_if tok ();

  command_line_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (chr),
    .tok_o  (tok)
  );

  char_beat_t chars_to_send[$];
  tok_beat_t  tokens_due[$];
  tok_beat_t  step_toks[$];

  int errors     = 0;
  int items_made = 0;
  int src_idle   = 0;
  int snk_idle   = 0;
  int quiet_cycles = 0;

  // Scanner state mirrored from the line being fed in
  scan_mode_e  mode;
  logic [15:0] line_pos;
  logic [15:0] run_start;
  logic [15:0] run_len;
  logic        true_alive;
  logic        false_alive;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic note_error(input string msg);
    if (errors < MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic digit_ch(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic lower_ch(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic white_ch(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  task automatic emit_tok(input token_kind_e k, input logic bv, input logic [15:0] s,
                          input logic [15:0] l);
    step_toks.push_back('{kind: k, bval: bv, start: s, len: l, last: 1'b0});
  endtask

  task automatic clear_scan();
    mode        = SCAN_IDLE;
    line_pos    = '0;
    run_start   = '0;
    run_len     = '0;
    true_alive  = 1'b0;
    false_alive = 1'b0;
  endtask

  task automatic scan_from_idle(input logic [7:0] c, input logic at_end);
    mode = SCAN_IDLE;
    if (at_end) begin
      emit_tok(KIND_END, 1'b0, line_pos, 16'd0);
      clear_scan();
    end else begin
      if (c == CHAR_EQUAL) begin
        emit_tok(KIND_EQUAL, 1'b0, line_pos, 16'd1);
      end else if (c == CHAR_QUOTE) begin
        mode      = SCAN_STRING;
        run_start = bump(line_pos);
        run_len   = '0;
      end else if (digit_ch(c)) begin
        mode      = SCAN_NUMBER;
        run_start = line_pos;
        run_len   = 16'd1;
      end else if (lower_ch(c)) begin
        mode        = SCAN_LITERAL;
        run_start   = line_pos;
        run_len     = 16'd1;
        true_alive  = (c == TRUE_WORD[31:24]);
        false_alive = (c == FALSE_WORD[39:32]);
      end else if (c != CHAR_SPACE) begin
        emit_tok(KIND_INVALID, 1'b0, line_pos, 16'd1);
      end
      line_pos = bump(line_pos);
    end
  endtask

  // Work out every token that one accepted character gives rise to
  task automatic scan_char(input logic [7:0] c, input logic eot);
    logic at_end;
    logic term;
    at_end = eot || (c == CHAR_NUL);
    step_toks.delete();
    case (mode)
      SCAN_STRING: begin
        if (at_end) begin
          emit_tok(KIND_UNCLOSED, 1'b0, run_start, run_len);
          scan_from_idle(c, 1'b1);
        end else if (c == CHAR_QUOTE) begin
          emit_tok(KIND_STRING, 1'b0, run_start, run_len);
          mode     = SCAN_IDLE;
          line_pos = bump(line_pos);
        end else begin
          run_len  = bump(run_len);
          line_pos = bump(line_pos);
        end
      end
      SCAN_NUMBER: begin
        if (!at_end && digit_ch(c)) begin
          run_len  = bump(run_len);
          line_pos = bump(line_pos);
        end else begin
          emit_tok(KIND_NUMBER, 1'b0, run_start, run_len);
          scan_from_idle(c, at_end);
        end
      end
      SCAN_LITERAL: begin
        if (!at_end && (lower_ch(c) || digit_ch(c))) begin
          true_alive  = true_alive && (run_len < 16'd4) &&
                        (c == TRUE_WORD[8*(3 - int'(run_len)) +: 8]);
          false_alive = false_alive && (run_len < 16'd5) &&
                        (c == FALSE_WORD[8*(4 - int'(run_len)) +: 8]);
          run_len  = bump(run_len);
          line_pos = bump(line_pos);
        end else begin
          term = at_end || white_ch(c);
          if (term && true_alive && run_len == 16'd4)
            emit_tok(KIND_BOOL, 1'b1, run_start, run_len);
          else if (term && false_alive && run_len == 16'd5)
            emit_tok(KIND_BOOL, 1'b0, run_start, run_len);
          else
            emit_tok(KIND_LITERAL, 1'b0, run_start, run_len);
          true_alive  = 1'b0;
          false_alive = 1'b0;
          scan_from_idle(c, at_end);
        end
      end
      default: scan_from_idle(c, at_end);
    endcase
    if (step_toks.size() != 0) step_toks[$].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endtask

  task automatic add_item(input logic [7:0] c, input logic eot);
    chars_to_send.push_back('{ch: c, eot: eot});
    items_made++;
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) add_item(s[i], 1'b0);
  endtask

  function automatic string bool_word(input int idx);
    case (idx)
      0:       return "true";
      1:       return "false";
      2:       return "tru";
      3:       return "truee";
      4:       return "fals";
      5:       return "falsee";
      6:       return "true9";
      default: return "ffalse";
    endcase
  endfunction

  task automatic add_random_line();
    int n_tok;
    int len;
    int sep;
    logic [7:0] c;
    logic unclosed;
    n_tok    = $urandom_range(1, 6);
    unclosed = 1'b0;
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 9))
        0: add_item(CHAR_EQUAL, 1'b0);
        1, 2: begin
          len = $urandom_range(1, 4);
          repeat (len) add_item(8'h30 + 8'($urandom_range(0, 9)), 1'b0);
        end
        3, 4: begin
          add_item(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
          len = $urandom_range(0, 5);
          repeat (len) begin
            if ($urandom_range(0, 2) == 0) c = 8'h30 + 8'($urandom_range(0, 9));
            else c = 8'h61 + 8'($urandom_range(0, 25));
            add_item(c, 1'b0);
          end
        end
        5, 6: push_text(bool_word($urandom_range(0, 7)));
        7, 8: begin
          add_item(CHAR_QUOTE, 1'b0);
          len = $urandom_range(0, 5);
          repeat (len) begin
            do c = 8'($urandom_range(1, 255)); while (c == CHAR_QUOTE);
            add_item(c, 1'b0);
          end
          if ($urandom_range(0, 5) == 0) unclosed = 1'b1;
          else add_item(CHAR_QUOTE, 1'b0);
        end
        default: add_item(8'($urandom_range(0, 255)), 1'b0);
      endcase
      if (unclosed) break;
      sep = $urandom_range(0, 9);
      if (sep < 7) repeat ($urandom_range(1, 2)) add_item(CHAR_SPACE, 1'b0);
      else if (sep == 8) add_item(8'($urandom_range(9, 13)), 1'b0);
    end
    if ($urandom_range(0, 4) == 0) add_item(CHAR_NUL, 1'b0);
    else add_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic add_random(input int n);
    int target;
    target = items_made + n;
    while (items_made < target) add_random_line();
  endtask

  task automatic wait_drained();
    while (chars_to_send.size() != 0 || chr.valid || tokens_due.size() != 0)
      @(negedge clk_i);
  endtask

  // Driver: one character beat at a time, sink ready drawn each cycle
  always @(posedge clk_i or negedge rst_ni) begin : drive
    char_beat_t nxt;
    if (!rst_ni) begin
      chr.valid       <= 1'b0;
      chr.character   <= '0;
      chr.end_of_text <= 1'b0;
      tok.ready       <= 1'b0;
    end else begin
      tok.ready <= ($urandom_range(99) >= snk_idle);
      if (!chr.valid || chr.ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= src_idle) begin
          nxt = chars_to_send.pop_front();
          chr.valid       <= 1'b1;
          chr.character   <= nxt.ch;
          chr.end_of_text <= nxt.eot;
        end else begin
          chr.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each input beat, then check each token beat
  always @(posedge clk_i) begin : watch
    tok_beat_t want;
    if (rst_ni) begin
      if (chr.valid && chr.ready) scan_char(chr.character, chr.end_of_text);
      if (tok.valid && tok.ready) begin
        if (tokens_due.size() == 0) begin
          note_error($sformatf("token beat kind %0d start %0d with nothing due",
                               tok.token_kind, tok.token_start));
        end else begin
          want = tokens_due.pop_front();
          if (tok.token_kind !== want.kind)
            note_error($sformatf("token_kind %0d, want %0d", tok.token_kind, want.kind));
          if (tok.bool_value !== want.bval)
            note_error($sformatf("bool_value %0b, want %0b", tok.bool_value, want.bval));
          if (tok.token_start !== want.start)
            note_error($sformatf("token_start %0d, want %0d", tok.token_start, want.start));
          if (tok.token_length !== want.len)
            note_error($sformatf("token_length %0d, want %0d", tok.token_length, want.len));
          if (tok.last_of_run !== want.last)
            note_error($sformatf("last_of_run %0b, want %0b", tok.last_of_run, want.last));
        end
      end
      if ((chr.valid && chr.ready) || (tok.valid && tok.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR @%0t: no beat for %0d cycles, %0d tokens due",
                 $time, quiet_cycles, tokens_due.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    clear_scan();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle = 27;
    snk_idle = 88;
    // bools by space and by end, literal/equal/number/unclosed string,
    // bool ended by tab, invalid characters, end with a nonzero character
    push_text("true false");
    add_item(8'hff, 1'b1);
    push_text("k=7\"ab");
    add_item(CHAR_NUL, 1'b0);
    push_text("true");
    add_item(CHAR_TAB, 1'b0);
    add_item(8'h41, 1'b0);
    add_item(8'hff, 1'b0);
    add_item(CHAR_NUL, 1'b1);
    add_random(170);
    // hold the sender until every token has come back
    wait_drained();

    src_idle = 88;
    snk_idle = 27;
    add_random(170);
    wait_drained();

    src_idle = 0;
    snk_idle = 0;
    add_random(120);
    // long string, then an equal and a number ended by the end of text
    add_item(CHAR_QUOTE, 1'b0);
    repeat (40) add_item(8'h71, 1'b0);
    add_item(CHAR_QUOTE, 1'b0);
    add_item(CHAR_EQUAL, 1'b0);
    push_text("12");
    add_item(8'h00, 1'b1);
    add_random(20);
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (tokens_due.size() != 0)
      note_error($sformatf("%0d tokens never arrived", tokens_due.size()));
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
